// ===== rtl/core/lfusbt_pkg.sv =====
// Shared types and constants for the LFU size-budget table.
// No dependencies; every other source file but lfusbt_if imports this package.
package lfusbt_pkg;

    localparam int ENTRIES    = 16;
    localparam int COUNT_BITS = 16;
    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // Request kinds.
    localparam logic [2:0] KIND_REGISTER = 3'd0;
    localparam logic [2:0] KIND_RESIZE   = 3'd1;
    localparam logic [2:0] KIND_REMOVE   = 3'd2;
    localparam logic [2:0] KIND_TOUCH    = 3'd3;
    localparam logic [2:0] KIND_QUERY    = 3'd4;

    // Result status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_OVER      = 2'd2;

    // Result kinds.
    localparam logic RK_FINAL = 1'b0;
    localparam logic RK_SPILL = 1'b1;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_REM_FIN
    } state_t;

    typedef enum logic [1:0] {
        CELL_INSERT,
        CELL_RESIZE,
        CELL_TOUCH,
        CELL_CLEAR
    } cell_op_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic             shift;
        logic [31:0]      scan_key;
        logic             scan_excl;
        logic [31:0]      stamp_now;
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        cell_op_t         wr_op;
        logic [31:0]      wr_key;
        logic [31:0]      wr_size;
        logic             wr_tag;
    } cell_cmd_t;

    // Search token handed from cell to cell.
    typedef struct packed {
        logic                  hit;
        logic [IDX_W-1:0]      hit_idx;
        logic [31:0]           hit_size;
        logic                  hit_tag;
        logic [COUNT_BITS-1:0] hit_count;
        logic                  free_ok;
        logic [IDX_W-1:0]      free_idx;
        logic                  vic_ok;
        logic [IDX_W-1:0]      vic_idx;
        logic [COUNT_BITS-1:0] vic_count;
        logic [31:0]           vic_age;
        logic [31:0]           vic_key;
        logic [31:0]           vic_size;
        logic                  vic_tag;
    } token_t;

    typedef struct packed {
        logic        result_kind;
        logic [31:0] result_key;
        logic [31:0] result_size;
        logic        result_is_table;
        logic        present;
        logic [31:0] total_used;
        logic [1:0]  status;
        logic        last;
    } rsp_t;

endpackage

// ===== rtl/core/lfusbt_if.sv =====
// Request and response channel interfaces of the LFU size-budget table.
// Depends on nothing but plain logic types.
interface lfusbt_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [31:0] entry_key;
    logic [31:0] size_bytes;
    logic        is_table;

    modport source (output valid, kind, entry_key, size_bytes, is_table, input ready);
    modport sink   (input valid, kind, entry_key, size_bytes, is_table, output ready);
endinterface

interface lfusbt_rsp_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [31:0] result_key;
    logic [31:0] result_size;
    logic        result_is_table;
    logic        present;
    logic [31:0] total_used;
    logic [1:0]  status;
    logic        last;

    modport source (output valid, result_kind, result_key, result_size, result_is_table,
                    present, total_used, status, last, input ready);
    modport sink   (input valid, result_kind, result_key, result_size, result_is_table,
                    present, total_used, status, last, output ready);
endinterface

// ===== rtl/core/lfu_size_budget_table.sv =====
// Top level of the LFU size-budget table: controller plus the chain of slot cells.
// Depends on lfusbt_pkg, lfusbt_if and lfusbt_cell.
//
//  Channel  Dir  Handshake          Carries
//  req      in   valid/ready        kind, entry_key, size_bytes, is_table
//  rsp      out  valid/ready        spill records and one final result per request
//  cfg      in   cfg_we (no stall)  memory_budget
//
// A request is taken in the idle state, the token then walks the ENTRIES cells in the
// scan state and the decide state emits a result; a remove adds a closing state. Each
// eviction of a register or resize adds a rescan of the cells. Reset empties the table,
// zeroes the total, id and stamp counters and sets the budget to all ones. A stalled
// response holds the controller in its decide or closing state until the response
// drains.
module lfu_size_budget_table
    import lfusbt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    lfusbt_req_if.sink   req,
    lfusbt_rsp_if.source rsp,
    input  logic         cfg_we,
    input  logic [31:0]  cfg_wdata
);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [31:0]      budget_reg;
    logic [31:0]      used_reg, used_next;
    logic [31:0]      next_key_reg, next_key_next;
    logic [31:0]      stamp_reg, stamp_next;
    logic [2:0]       kind_reg;
    logic [31:0]      key_reg;
    logic [31:0]      size_reg;
    logic             tag_reg;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_reg, rsp_next;
    cell_cmd_t        cmd;
    token_t           token_w [ENTRIES+1];
    token_t           tok;
    logic             out_free;
    logic             is_alloc;
    logic             miss;
    logic [32:0]      need;
    logic             fits;
    logic             go_rescan;
    logic             go_remfin;

    // Cell chain.
    assign token_w[0] = '0;
    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        lfusbt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .my_idx    (IDX_W'(g)),
            .cmd       (cmd),
            .token_in  (token_w[g]),
            .token_out (token_w[g+1])
        );
    end
    assign tok = token_w[ENTRIES];

    // Decision terms from the finished scan.
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign is_alloc  = (kind_reg == KIND_REGISTER) || (kind_reg == KIND_RESIZE);
    assign miss      = (kind_reg >= KIND_RESIZE) && (kind_reg <= KIND_QUERY) && !tok.hit;
    assign need      = {1'b0, used_reg}
                     - ((kind_reg == KIND_RESIZE) ? {1'b0, tok.hit_size} : 33'd0)
                     + {1'b0, size_reg};
    assign fits      = (need <= {1'b0, budget_reg}) &&
                       ((kind_reg == KIND_RESIZE) || tok.free_ok);
    assign go_rescan = is_alloc && !miss && !fits && tok.vic_ok;
    assign go_remfin = (kind_reg == KIND_REMOVE) && !miss;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == IDX_W'(ENTRIES - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_DECIDE;
                end
                else
                begin
                    cnt_next = cnt_reg + IDX_W'(1);
                end
            end
            ST_DECIDE:
            begin
                if (out_free)
                begin
                    priority if (go_rescan)
                        state_next = ST_SCAN;
                    else if (go_remfin)
                        state_next = ST_REM_FIN;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_REM_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // Outputs, cell commands and datapath updates.
    always_comb
    begin
        used_next      = used_reg;
        next_key_next  = next_key_reg;
        stamp_next     = stamp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_next       = rsp_reg;
        cmd            = '0;
        cmd.shift      = (state_reg == ST_SCAN);
        cmd.scan_key   = key_reg;
        cmd.scan_excl  = (kind_reg == KIND_RESIZE);
        cmd.stamp_now  = stamp_reg;
        cmd.wr_key     = next_key_reg + 32'd1;
        cmd.wr_size    = size_reg;
        cmd.wr_tag     = tag_reg;
        cmd.wr_op      = CELL_CLEAR;
        req.ready      = (state_reg == ST_IDLE);

        if ((state_reg == ST_DECIDE) && out_free)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = '0;
            rsp_next.last  = 1'b1;
            priority if (kind_reg > KIND_QUERY)
            begin
            end
            else if (miss)
            begin
                rsp_next.result_key = key_reg;
                rsp_next.status     = STATUS_NOT_FOUND;
            end
            else if (is_alloc)
            begin
                priority if (fits)
                begin
                    cmd.wr_en                = 1'b1;
                    rsp_next.result_size     = size_reg;
                    rsp_next.present         = 1'b1;
                    used_next                = need[31:0];
                    if (kind_reg == KIND_REGISTER)
                    begin
                        cmd.wr_idx               = tok.free_idx;
                        cmd.wr_op                = CELL_INSERT;
                        next_key_next            = next_key_reg + 32'd1;
                        stamp_next               = stamp_reg + 32'd1;
                        rsp_next.result_key      = next_key_reg + 32'd1;
                        rsp_next.result_is_table = tag_reg;
                    end
                    else
                    begin
                        cmd.wr_idx               = tok.hit_idx;
                        cmd.wr_op                = CELL_RESIZE;
                        rsp_next.result_key      = key_reg;
                        rsp_next.result_is_table = tok.hit_tag;
                    end
                end
                else if (tok.vic_ok)
                begin
                    cmd.wr_en                = 1'b1;
                    cmd.wr_idx               = tok.vic_idx;
                    used_next                = used_reg - tok.vic_size;
                    rsp_next.result_kind     = RK_SPILL;
                    rsp_next.result_key      = tok.vic_key;
                    rsp_next.result_size     = tok.vic_size;
                    rsp_next.result_is_table = tok.vic_tag;
                    rsp_next.last            = 1'b0;
                end
                else
                begin
                    rsp_next.status = STATUS_OVER;
                    if (kind_reg == KIND_RESIZE)
                    begin
                        rsp_next.result_key      = key_reg;
                        rsp_next.result_size     = tok.hit_size;
                        rsp_next.result_is_table = tok.hit_tag;
                        rsp_next.present         = 1'b1;
                    end
                end
            end
            else if (kind_reg == KIND_REMOVE)
            begin
                cmd.wr_en                = 1'b1;
                cmd.wr_idx               = tok.hit_idx;
                used_next                = used_reg - tok.hit_size;
                rsp_next.result_kind     = RK_SPILL;
                rsp_next.result_key      = key_reg;
                rsp_next.result_size     = tok.hit_size;
                rsp_next.result_is_table = tok.hit_tag;
                rsp_next.last            = 1'b0;
            end
            else
            begin
                if ((kind_reg == KIND_TOUCH) && (tok.hit_count != COUNT_MAX))
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_idx = tok.hit_idx;
                    cmd.wr_op  = CELL_TOUCH;
                    stamp_next = stamp_reg + 32'd1;
                end
                rsp_next.result_key      = key_reg;
                rsp_next.result_size     = tok.hit_size;
                rsp_next.result_is_table = tok.hit_tag;
                rsp_next.present         = 1'b1;
            end
            rsp_next.total_used = used_next;
        end
        else if ((state_reg == ST_REM_FIN) && out_free)
        begin
            rsp_valid_next      = 1'b1;
            rsp_next            = '0;
            rsp_next.result_key = key_reg;
            rsp_next.total_used = used_reg;
            rsp_next.last       = 1'b1;
        end
    end

    // Control and counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            budget_reg    <= '1;
            used_reg      <= '0;
            next_key_reg  <= '0;
            stamp_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            used_reg      <= used_next;
            next_key_reg  <= next_key_next;
            stamp_reg     <= stamp_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                budget_reg <= cfg_wdata;
            end
        end
    end

    // Request capture and response payload.
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            kind_reg <= req.kind;
            key_reg  <= req.entry_key;
            size_reg <= req.size_bytes;
            tag_reg  <= req.is_table;
        end
        rsp_reg <= rsp_next;
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.result_kind     = rsp_reg.result_kind;
    assign rsp.result_key      = rsp_reg.result_key;
    assign rsp.result_size     = rsp_reg.result_size;
    assign rsp.result_is_table = rsp_reg.result_is_table;
    assign rsp.present         = rsp_reg.present;
    assign rsp.total_used      = rsp_reg.total_used;
    assign rsp.status          = rsp_reg.status;
    assign rsp.last            = rsp_reg.last;

`ifndef SYNTHESIS
    // An accepted request always starts a scan.
    a_req_scan: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> state_reg == ST_SCAN)
        else $error("request did not start a scan");

    // Spill records are never the closing result and always carry status ok.
    a_spill_form: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.result_kind == RK_SPILL) |-> !rsp.last && (rsp.status == STATUS_OK))
        else $error("malformed spill record");

    // The scan counter is idle outside scans.
    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_SCAN |-> cnt_reg == '0)
        else $error("scan counter running outside a scan");
`endif

endmodule

// ===== rtl/core/lfusbt_cell.sv =====
// One table slot: holds an entry and refines the search token passing through.
// Depends on lfusbt_pkg.
module lfusbt_cell
    import lfusbt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] my_idx,
    input  cell_cmd_t        cmd,
    input  token_t           token_in,
    output token_t           token_out
);

    logic                  valid_reg;
    logic [31:0]           key_reg;
    logic [31:0]           size_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [31:0]           stamp_reg;
    logic                  tag_reg;
    token_t                token_reg;
    token_t                token_next;
    logic                  match;
    logic [31:0]           age;
    logic                  wr_hit;

    assign match  = valid_reg && (key_reg == cmd.scan_key);
    assign age    = cmd.stamp_now - stamp_reg;
    assign wr_hit = cmd.wr_en && (cmd.wr_idx == my_idx);

    // Fold this slot into the token: first key hit, first free slot, best victim.
    always_comb
    begin
        token_next = token_in;
        if (match && !token_in.hit)
        begin
            token_next.hit       = 1'b1;
            token_next.hit_idx   = my_idx;
            token_next.hit_size  = size_reg;
            token_next.hit_tag   = tag_reg;
            token_next.hit_count = count_reg;
        end
        if (!valid_reg && !token_in.free_ok)
        begin
            token_next.free_ok  = 1'b1;
            token_next.free_idx = my_idx;
        end
        if (valid_reg && !(cmd.scan_excl && match) &&
            (!token_in.vic_ok || (count_reg < token_in.vic_count) ||
             ((count_reg == token_in.vic_count) && (age > token_in.vic_age))))
        begin
            token_next.vic_ok    = 1'b1;
            token_next.vic_idx   = my_idx;
            token_next.vic_count = count_reg;
            token_next.vic_age   = age;
            token_next.vic_key   = key_reg;
            token_next.vic_size  = size_reg;
            token_next.vic_tag   = tag_reg;
        end
    end

    // Token stage toward the next cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_reg <= '0;
        end
        else if (cmd.shift)
        begin
            token_reg <= token_next;
        end
    end

    assign token_out = token_reg;

    // Slot valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (wr_hit)
        begin
            valid_reg <= (cmd.wr_op != CELL_CLEAR);
        end
    end

    // Slot payload.
    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            unique case (cmd.wr_op)
                CELL_INSERT:
                begin
                    key_reg   <= cmd.wr_key;
                    size_reg  <= cmd.wr_size;
                    tag_reg   <= cmd.wr_tag;
                    count_reg <= COUNT_BITS'(1);
                    stamp_reg <= cmd.stamp_now;
                end
                CELL_RESIZE:
                begin
                    size_reg <= cmd.wr_size;
                end
                CELL_TOUCH:
                begin
                    count_reg <= count_reg + COUNT_BITS'(1);
                    stamp_reg <= cmd.stamp_now;
                end
                CELL_CLEAR:
                begin
                end
            endcase
        end
    end

endmodule

// ===== bench/lfusbt_cache_checker.sv =====
// Checker for the LFU size-budget table: watches both channels, predicts every
// response from its own copy of the table and compares field by field.
// Depends on lfusbt_pkg and the lfusbt_req_if / lfusbt_rsp_if interfaces.
`timescale 1ns / 1ps

module lfusbt_cache_checker
    import lfusbt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    lfusbt_req_if       req,
    lfusbt_rsp_if       rsp,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    output int          fail_count,
    output int          pending_count
);

    // Predicted table contents.
    logic                  m_valid [ENTRIES];
    logic [31:0]           m_key   [ENTRIES];
    logic [31:0]           m_size  [ENTRIES];
    logic [COUNT_BITS-1:0] m_count [ENTRIES];
    logic [31:0]           m_stamp [ENTRIES];
    logic                  m_tag   [ENTRIES];
    logic [31:0]           m_total;
    logic [31:0]           m_next_id;
    logic [31:0]           m_clock;
    logic [31:0]           m_budget;

    rsp_t expected_rsps[$];

    function automatic int slot_of(logic [31:0] k);
        for (int i = 0; i < ENTRIES; i++)
            if (m_valid[i] && m_key[i] == k)
                return i;
        return -1;
    endfunction

    function automatic int free_slot();
        for (int i = 0; i < ENTRIES; i++)
            if (!m_valid[i])
                return i;
        return -1;
    endfunction

    // Lowest count wins; on a tie the oldest stamp, then the lowest slot.
    function automatic int lfu_victim(int skip);
        int best;
        logic [COUNT_BITS-1:0] bc;
        logic [31:0] ba;
        logic [31:0] age;
        best = -1;
        bc = '0;
        ba = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (!m_valid[i] || i == skip)
                continue;
            age = m_clock - m_stamp[i];
            if (best < 0 || m_count[i] < bc || (m_count[i] == bc && age > ba)) begin
                best = i;
                bc = m_count[i];
                ba = age;
            end
        end
        return best;
    endfunction

    function automatic void push_rsp(logic rk, logic [31:0] k, logic [31:0] sz, logic tg,
                                     logic pr, logic [1:0] st, logic lst);
        rsp_t r;
        r.result_kind = rk;
        r.result_key = k;
        r.result_size = sz;
        r.result_is_table = tg;
        r.present = pr;
        r.total_used = m_total;
        r.status = st;
        r.last = lst;
        expected_rsps.push_back(r);
    endfunction

    function automatic void spill_slot(int v);
        m_total = m_total - m_size[v];
        m_valid[v] = 1'b0;
        push_rsp(RK_SPILL, m_key[v], m_size[v], m_tag[v], 1'b0, STATUS_OK, 1'b0);
    endfunction

    function automatic void close_with(int s, logic [31:0] k, logic [1:0] st);
        if (s >= 0)
            push_rsp(RK_FINAL, k, m_size[s], m_tag[s], 1'b1, st, 1'b1);
        else
            push_rsp(RK_FINAL, k, '0, 1'b0, 1'b0, st, 1'b1);
    endfunction

    // Apply one request to the predicted table and queue its responses.
    function automatic void predict_request(logic [2:0] kind, logic [31:0] k,
                                            logic [31:0] sz, logic tg);
        int s;
        int v;
        logic [31:0] prior;
        logic [32:0] need;
        logic room;
        s = -1;
        prior = '0;
        if (kind == KIND_REGISTER || kind == KIND_RESIZE) begin
            if (kind == KIND_RESIZE) begin
                s = slot_of(k);
                if (s < 0) begin
                    close_with(-1, k, STATUS_NOT_FOUND);
                    return;
                end
                prior = m_size[s];
            end
            forever begin
                need = {1'b0, m_total} - {1'b0, prior} + {1'b0, sz};
                room = (kind == KIND_RESIZE) || free_slot() >= 0;
                if (need <= {1'b0, m_budget} && room)
                    break;
                v = lfu_victim(s);
                if (v < 0) begin
                    if (kind == KIND_REGISTER)
                        close_with(-1, '0, STATUS_OVER);
                    else
                        close_with(s, k, STATUS_OVER);
                    return;
                end
                spill_slot(v);
            end
            if (kind == KIND_REGISTER) begin
                s = free_slot();
                m_next_id = m_next_id + 32'd1;
                m_valid[s] = 1'b1;
                m_key[s] = m_next_id;
                m_size[s] = sz;
                m_count[s] = COUNT_BITS'(1);
                m_stamp[s] = m_clock;
                m_clock = m_clock + 32'd1;
                m_tag[s] = tg;
                m_total = m_total + sz;
                close_with(s, m_next_id, STATUS_OK);
            end else begin
                m_total = m_total - prior + sz;
                m_size[s] = sz;
                close_with(s, k, STATUS_OK);
            end
            return;
        end
        if (kind > KIND_QUERY) begin
            push_rsp(RK_FINAL, '0, '0, 1'b0, 1'b0, STATUS_OK, 1'b1);
            return;
        end
        s = slot_of(k);
        if (s < 0) begin
            close_with(-1, k, STATUS_NOT_FOUND);
            return;
        end
        if (kind == KIND_REMOVE) begin
            spill_slot(s);
            close_with(-1, k, STATUS_OK);
        end else begin
            if (kind == KIND_TOUCH && m_count[s] != COUNT_MAX) begin
                m_count[s] = m_count[s] + COUNT_BITS'(1);
                m_stamp[s] = m_clock;
                m_clock = m_clock + 32'd1;
            end
            close_with(s, k, STATUS_OK);
        end
    endfunction

    // Compare one accepted response with the oldest expectation.
    function automatic void check_rsp();
        rsp_t e;
        if (expected_rsps.size() == 0) begin
            $error("unexpected response: key %0h", rsp.result_key);
            fail_count++;
            return;
        end
        e = expected_rsps.pop_front();
        if (rsp.result_kind !== e.result_kind) begin
            $error("result_kind: expected %0d, got %0d", e.result_kind, rsp.result_kind);
            fail_count++;
        end
        if (rsp.result_key !== e.result_key) begin
            $error("result_key: expected %0h, got %0h", e.result_key, rsp.result_key);
            fail_count++;
        end
        if (rsp.result_size !== e.result_size) begin
            $error("result_size: expected %0h, got %0h", e.result_size, rsp.result_size);
            fail_count++;
        end
        if (rsp.result_is_table !== e.result_is_table) begin
            $error("result_is_table: expected %0d, got %0d", e.result_is_table,
                   rsp.result_is_table);
            fail_count++;
        end
        if (rsp.present !== e.present) begin
            $error("present: expected %0d, got %0d", e.present, rsp.present);
            fail_count++;
        end
        if (rsp.total_used !== e.total_used) begin
            $error("total_used: expected %0h, got %0h", e.total_used, rsp.total_used);
            fail_count++;
        end
        if (rsp.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, rsp.status);
            fail_count++;
        end
        if (rsp.last !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, rsp.last);
            fail_count++;
        end
    endfunction

    // Track the table on every edge; responses are checked before the new request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                m_valid[i] = 1'b0;
                m_key[i] = '0;
                m_size[i] = '0;
                m_count[i] = '0;
                m_stamp[i] = '0;
                m_tag[i] = 1'b0;
            end
            m_total = '0;
            m_next_id = '0;
            m_clock = '0;
            m_budget = '1;
            fail_count = 0;
            expected_rsps.delete();
            pending_count = 0;
        end else begin
            if (rsp.valid && rsp.ready)
                check_rsp();
            if (req.valid && req.ready)
                predict_request(req.kind, req.entry_key, req.size_bytes, req.is_table);
            if (cfg_we)
                m_budget = cfg_wdata;
            pending_count = expected_rsps.size();
        end
    end

endmodule

// ===== bench/lfu_size_budget_table_tb.sv =====
// Testbench top for the LFU size-budget table: drives requests, budget writes
// and response backpressure; the checker beside the block does the comparing.
// Depends on lfusbt_pkg, lfusbt_if, lfu_size_budget_table and lfusbt_cache_checker.
`timescale 1ns / 1ps

module lfu_size_budget_table_tb;
    import lfusbt_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;
    int          fail_count;
    int          pending_count;
    int          idle_cycles;
    logic        req_quiet;
    logic [31:0] live_ids[$];
    logic [31:0] budget_now;

    lfusbt_req_if req ();
    lfusbt_rsp_if rsp ();

    lfu_size_budget_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    lfusbt_cache_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .rsp           (rsp),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    endfunction

    // Response backpressure, with quiet stretches where ready stays high.
    initial
    begin
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (req_quiet)
                rsp.ready <= 1'b1;
            else
                rsp.ready <= (gap_len() == 0);
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic send_req(logic [2:0] kind, logic [31:0] k, logic [31:0] sz, logic tg);
        int g;
        g = req_quiet ? 0 : gap_len();
        // Valid drops between two requests, also when the gap is zero.
        repeat (g + 1) @(posedge clk);
        req.valid <= 1'b1;
        req.kind <= kind;
        req.entry_key <= k;
        req.size_bytes <= sz;
        req.is_table <= tg;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        req.valid <= 1'b0;
        // Guess the new id from the block's numbering; a refused register makes the
        // guess run ahead, which only turns some later requests into misses.
        if (kind == KIND_REGISTER)
            live_ids.push_back(live_ids.size() == 0 ? 32'd1 : live_ids[$] + 1);
    endtask

    task automatic drain_then_set_budget(logic [31:0] b);
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (ENTRIES * 4) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= b;
        budget_now = b;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0 || live_ids.size() == 0)
            return $urandom();
        if (r == 1)
            return live_ids[live_ids.size() - 1] + 1;
        return live_ids[$urandom_range(0, live_ids.size() - 1)];
    endfunction

    function automatic logic [31:0] pick_size();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return $urandom();
        if (r == 1)
            return budget_now;
        return $urandom_range(0, (budget_now < 200) ? budget_now : 200);
    endfunction

    task automatic random_phase(int n);
        logic [2:0] kind;
        for (int i = 0; i < n; i++) begin
            kind = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                                : 3'($urandom_range(0, 4));
            send_req(kind, pick_key(), pick_size(), 1'($urandom()));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        req.valid = 1'b0;
        req.kind = KIND_REGISTER;
        req.entry_key = '0;
        req.size_bytes = '0;
        req.is_table = 1'b0;
        req_quiet = 1'b0;
        idle_cycles = 0;
        budget_now = '1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: full budget, fill the table past capacity, every kind.
        send_req(KIND_REGISTER, '0, 32'hFFFF_FFFF, 1'b1);
        send_req(KIND_QUERY, 32'd1, '0, 1'b0);
        send_req(KIND_RESIZE, 32'd1, '0, 1'b0);
        for (int i = 0; i < 16; i++)
            send_req(KIND_REGISTER, 32'hFFFF_FFFF, 32'(i + 1), 1'(i));
        send_req(KIND_TOUCH, 32'd5, '0, 1'b0);
        send_req(KIND_REMOVE, 32'd6, '0, 1'b0);
        send_req(KIND_REMOVE, 32'd6, '0, 1'b0);
        send_req(KIND_TOUCH, 32'hFFFF_FFFF, '0, 1'b0);
        send_req(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);

        // Tight budget: evictions and over-budget refusals.
        drain_then_set_budget(32'd0);
        send_req(KIND_REGISTER, '0, 32'd1, 1'b0);
        send_req(KIND_REGISTER, '0, 32'd0, 1'b1);
        send_req(KIND_RESIZE, live_ids[$], 32'd5, 1'b0);
        drain_then_set_budget(32'd300);
        random_phase(40);

        // Repeated touches on one entry, with no random gaps and response ready held high.
        req_quiet = 1'b1;
        drain_then_set_budget(32'hFFFF_FFFF);
        send_req(KIND_REGISTER, '0, 32'd10, 1'b0);
        for (int i = 0; i < 20; i++)
            send_req(KIND_TOUCH, live_ids[$], '0, 1'b0);
        req_quiet = 1'b0;

        drain_then_set_budget(32'd1000);
        random_phase(20);
        drain_then_set_budget(32'd120);
        random_phase(20);

        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (ENTRIES * 4) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/lfusbt_pkg.sv
rtl/core/lfusbt_if.sv
rtl/core/lfusbt_cell.sv
rtl/core/lfu_size_budget_table.sv
bench/lfusbt_cache_checker.sv
bench/lfu_size_budget_table_tb.sv
